>>> rtl/spl_pkg.sv
// Shared constants, tables and helper functions of the stereo peak limiter.
package spl_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int LOG_FRAC_BITS = 20;
    localparam int THR_BITS      = 11;
    localparam int COEFF_BITS    = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int DIV_NUM_BITS  = 60;
    localparam int DIV_DEN_BITS  = 28;
    localparam int DIV_Q_BITS    = 33;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 2'd2;

    localparam logic signed [THR_BITS-1:0] THR_RESET     = -11'sd10;
    localparam logic [COEFF_BITS-1:0]      ATTACK_RESET  = 24'd34914;
    localparam logic [COEFF_BITS-1:0]      RELEASE_RESET = 24'd175;

    localparam logic [DIV_DEN_BITS-1:0] LN2_Q28   = 28'd186065279;
    localparam logic [63:0]             THR_K_Q32 = 64'd49615462;
    localparam logic [63:0] FLOOR_LOG =
        ((64'd110 * 64'd186065279 << LOG_FRAC_BITS) + (64'd1 << 27)) >> 28;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = 64'd0;
        bt  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bt > v)
                bt = bt >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bt != 64'd0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [29:0] exp_fac(input int k);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 0; i < k; i++)
            c = isqrt64(c << 30);
        return c[29:0];
    endfunction

    localparam logic [29:0] EXP_FAC [LOG_FRAC_BITS] = '{
        exp_fac(1),  exp_fac(2),  exp_fac(3),  exp_fac(4),  exp_fac(5),
        exp_fac(6),  exp_fac(7),  exp_fac(8),  exp_fac(9),  exp_fac(10),
        exp_fac(11), exp_fac(12), exp_fac(13), exp_fac(14), exp_fac(15),
        exp_fac(16), exp_fac(17), exp_fac(18), exp_fac(19), exp_fac(20)
    };

    function automatic logic signed [25:0] thr_log(input logic signed [THR_BITS-1:0] t);
        logic [THR_BITS-1:0] mag;
        logic [63:0]         prod;
        logic [25:0]         rnd;
        mag  = t[THR_BITS-1] ? THR_BITS'(-t) : THR_BITS'(t);
        prod = 64'(mag) * THR_K_Q32;
        rnd  = 26'((prod + (64'd1 << (31 - LOG_FRAC_BITS))) >> (32 - LOG_FRAC_BITS));
        return t[THR_BITS-1] ? -$signed(rnd) : $signed(rnd);
    endfunction

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

>>> rtl/spl_div.sv
// Bit-serial restoring divider that divides a gain magnitude shifted by 28 by ln 2 in Q28.
module spl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   dividend,
    output logic                          done,
    output logic [spl_pkg::DIV_Q_BITS-1:0] quotient
);

    logic [spl_pkg::DIV_DEN_BITS-1:0] rem_reg;
    logic [spl_pkg::DIV_NUM_BITS-1:0] num_reg;
    logic [spl_pkg::DIV_Q_BITS-1:0]   quo_reg;
    logic [5:0]                       cnt_reg;
    logic                             run_reg;
    logic                             done_reg;
    logic [spl_pkg::DIV_DEN_BITS:0]   sh;
    logic                             ge;

    assign sh = {rem_reg, num_reg[spl_pkg::DIV_NUM_BITS-1]};
    assign ge = sh >= {1'b0, spl_pkg::LN2_Q28};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= '0;
                num_reg <= {dividend, 28'd0};
                quo_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= ge ? spl_pkg::DIV_DEN_BITS'(sh - {1'b0, spl_pkg::LN2_Q28})
                              : sh[spl_pkg::DIV_DEN_BITS-1:0];
                num_reg <= {num_reg[spl_pkg::DIV_NUM_BITS-2:0], 1'b0};
                quo_reg <= {quo_reg[spl_pkg::DIV_Q_BITS-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(spl_pkg::DIV_NUM_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/stereo_peak_limiter_core.sv
// Top level of the stereo peak limiter: log detector, gain smoother, exp and scaling.
//
// One stereo word enters on in_valid/in_stall and one scaled word leaves on
// out_valid/out_stall. A word is taken when valid is high and stall is low.
// The block works on one word at a time and holds in_stall high from the
// cycle after it takes a word until that word has reached the output register.
// A word passes through one-bit normalization, squaring for the log, a wait
// on the bit-serial divider and the exp product; the squaring, the log, the
// gain step, the exp product and the scaling share one 33x31 multiplier.
// Silent words skip the squaring, and words whose smoothed gain is unity skip
// the divider and the exp product. The result sits in an output register, so
// the next word is taken while the receiver stalls; the block only waits at
// its final step if the previous result has not been taken yet. Nothing is
// lost while out_stall is high. Configuration writes on cfg_valid/cfg_ready
// are always accepted and must be made while the block is idle. Reset
// restores the default threshold and coefficients and sets the smoothed gain
// to unity.
module stereo_peak_limiter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [spl_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [spl_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [spl_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [spl_pkg::SAMPLE_BITS-1:0] right_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [spl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQ, S_LN, S_TGT, S_STEP, S_DSTART, S_DWAIT,
        S_EXP, S_SHF, S_SCL_L, S_SCL_R
    } state_t;

    state_t                                state_reg;
    logic signed [spl_pkg::THR_BITS-1:0]   thr_tenths_reg;
    logic [spl_pkg::COEFF_BITS-1:0]        attack_reg;
    logic [spl_pkg::COEFF_BITS-1:0]        release_reg;
    logic signed [25:0]                    thr_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] l_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] r_reg;
    logic [30:0]                           x_reg;
    logic [4:0]                            p_reg;
    logic [27:0]                           frac_reg;
    logic [4:0]                            cnt_reg;
    logic signed [27:0]                    level_reg;
    logic [32:0]                           dmag_reg;
    logic                                  dneg_reg;
    logic [spl_pkg::COEFF_BITS-1:0]        coeff_reg;
    logic signed [31:0]                    gain_reg;
    logic [12:0]                           n_reg;
    logic [spl_pkg::LOG_FRAC_BITS-1:0]     r_bits_reg;
    logic [30:0]                           res_reg;
    logic [30:0]                           glin_reg;
    logic [spl_pkg::SAMPLE_BITS-1:0]       ltmp_reg;
    logic                                  out_valid_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] left_out_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] right_out_reg;

    logic [32:0]                     mul_a;
    logic [30:0]                     mul_b;
    logic [63:0]                     prod;
    logic [spl_pkg::SAMPLE_BITS-1:0] in_mag_l;
    logic [spl_pkg::SAMPLE_BITS-1:0] in_mag_r;
    logic [spl_pkg::SAMPLE_BITS-1:0] in_mag;
    logic [31:0]                     sq;
    logic [32:0]                     nl;
    logic [27:0]                     lvl_mag;
    logic signed [28:0]              tgt;
    logic signed [33:0]              dval;
    logic [33:0]                     step;
    logic signed [34:0]              ng;
    logic signed [31:0]              ng_sat;
    logic                            sc_neg;
    logic [spl_pkg::SAMPLE_BITS-1:0] sc_mag;
    logic [spl_pkg::SAMPLE_BITS-1:0] sc_p;
    logic [spl_pkg::SAMPLE_BITS-1:0] sc_val;
    logic                            out_free;
    spl_pkg::div_ctl_t               div_ctl;
    logic [spl_pkg::DIV_Q_BITS-1:0]  div_q;

    spl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (32'(-33'(gain_reg))),
        .done     (div_ctl.done),
        .quotient (div_q)
    );

    assign div_ctl.start = (state_reg == S_DSTART);

    assign in_mag_l = left_sample[spl_pkg::SAMPLE_BITS-1]
                    ? spl_pkg::SAMPLE_BITS'(-left_sample) : spl_pkg::SAMPLE_BITS'(left_sample);
    assign in_mag_r = right_sample[spl_pkg::SAMPLE_BITS-1]
                    ? spl_pkg::SAMPLE_BITS'(-right_sample) : spl_pkg::SAMPLE_BITS'(right_sample);
    assign in_mag   = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;

    assign sc_neg = (state_reg == S_SCL_L) ? l_reg[spl_pkg::SAMPLE_BITS-1]
                                           : r_reg[spl_pkg::SAMPLE_BITS-1];
    assign sc_mag = (state_reg == S_SCL_L)
                  ? (sc_neg ? spl_pkg::SAMPLE_BITS'(-l_reg) : spl_pkg::SAMPLE_BITS'(l_reg))
                  : (sc_neg ? spl_pkg::SAMPLE_BITS'(-r_reg) : spl_pkg::SAMPLE_BITS'(r_reg));

    assign nl = {5'd23 - p_reg, 28'd0} - {5'd0, frac_reg};

    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = {2'd0, x_reg};
                mul_b = x_reg;
            end
            S_LN:
            begin
                mul_a = nl;
                mul_b = {3'd0, spl_pkg::LN2_Q28};
            end
            S_STEP:
            begin
                mul_a = dmag_reg;
                mul_b = {7'd0, coeff_reg};
            end
            S_EXP:
            begin
                mul_a = {2'd0, res_reg};
                mul_b = {1'b0, spl_pkg::EXP_FAC[cnt_reg]};
            end
            S_SCL_L, S_SCL_R:
            begin
                mul_a = {9'd0, sc_mag};
                mul_b = glin_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign sq      = prod[61:30];
    assign lvl_mag = 28'((prod + (64'd1 << 35)) >> 36);
    assign tgt     = (level_reg > 28'(thr_reg)) ? 29'(thr_reg) - 29'(level_reg) : 29'sd0;
    assign dval    = 34'(tgt) - 34'(gain_reg);
    assign step    = 34'((prod + (64'd1 << 23)) >> 24);
    assign ng      = dneg_reg ? 35'(gain_reg) - $signed({1'b0, step})
                              : 35'(gain_reg) + $signed({1'b0, step});
    assign ng_sat  = (ng > 35'sh07FFFFFFF) ? 32'sh7FFFFFFF
                   : (ng < -35'sh080000000) ? -32'sh80000000 : 32'(ng);
    assign sc_p    = spl_pkg::SAMPLE_BITS'((prod + (64'd1 << 29)) >> 30);
    assign sc_val  = sc_neg ? spl_pkg::SAMPLE_BITS'(-sc_p) : sc_p;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_tenths_reg <= spl_pkg::THR_RESET;
            attack_reg     <= spl_pkg::ATTACK_RESET;
            release_reg    <= spl_pkg::RELEASE_RESET;
            thr_reg        <= spl_pkg::thr_log(spl_pkg::THR_RESET);
            gain_reg       <= '0;
            out_valid_reg  <= 1'b0;
            l_reg          <= '0;
            r_reg          <= '0;
            x_reg          <= '0;
            p_reg          <= '0;
            frac_reg       <= '0;
            cnt_reg        <= '0;
            level_reg      <= '0;
            dmag_reg       <= '0;
            dneg_reg       <= 1'b0;
            coeff_reg      <= '0;
            n_reg          <= '0;
            r_bits_reg     <= '0;
            res_reg        <= '0;
            glin_reg       <= '0;
            ltmp_reg       <= '0;
            left_out_reg   <= '0;
            right_out_reg  <= '0;
        end
        else
        begin
            thr_reg <= spl_pkg::thr_log(thr_tenths_reg);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    spl_pkg::REG_THRESHOLD: thr_tenths_reg <= cfg_data[spl_pkg::THR_BITS-1:0];
                    spl_pkg::REG_ATTACK:    attack_reg     <= cfg_data;
                    spl_pkg::REG_RELEASE:   release_reg    <= cfg_data;
                    default:                ;
                endcase
            end
            if (out_valid_reg && !out_stall && state_reg != S_SCL_R)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        l_reg     <= left_sample;
                        r_reg     <= right_sample;
                        x_reg     <= {in_mag, 7'd0};
                        p_reg     <= 5'd23;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (x_reg == '0)
                    begin
                        level_reg <= -28'(spl_pkg::FLOOR_LOG);
                        state_reg <= S_TGT;
                    end
                    else if (x_reg[30])
                    begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        x_reg <= {x_reg[29:0], 1'b0};
                        p_reg <= p_reg - 5'd1;
                    end
                end
                S_SQ:
                begin
                    x_reg    <= sq[31] ? sq[31:1] : sq[30:0];
                    frac_reg <= {frac_reg[26:0], sq[31]};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd27)
                        state_reg <= S_LN;
                end
                S_LN:
                begin
                    level_reg <= -$signed(lvl_mag);
                    state_reg <= S_TGT;
                end
                S_TGT:
                begin
                    dneg_reg  <= dval[33];
                    dmag_reg  <= dval[33] ? 33'(-dval) : 33'(dval);
                    coeff_reg <= dval[33] ? attack_reg : release_reg;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    gain_reg <= ng_sat;
                    if (ng_sat >= 0)
                    begin
                        glin_reg  <= 31'd1 << 30;
                        state_reg <= S_SCL_L;
                    end
                    else
                    begin
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_ctl.done)
                    begin
                        n_reg      <= div_q[32:spl_pkg::LOG_FRAC_BITS];
                        r_bits_reg <= div_q[spl_pkg::LOG_FRAC_BITS-1:0];
                        res_reg    <= 31'd1 << 30;
                        cnt_reg    <= '0;
                        state_reg  <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (r_bits_reg[spl_pkg::LOG_FRAC_BITS-1])
                        res_reg <= prod[60:30];
                    r_bits_reg <= {r_bits_reg[spl_pkg::LOG_FRAC_BITS-2:0], 1'b0};
                    cnt_reg    <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(spl_pkg::LOG_FRAC_BITS - 1))
                        state_reg <= S_SHF;
                end
                S_SHF:
                begin
                    glin_reg  <= (n_reg >= 13'd31) ? 31'd0 : res_reg >> n_reg[4:0];
                    state_reg <= S_SCL_L;
                end
                S_SCL_L:
                begin
                    ltmp_reg  <= sc_val;
                    state_reg <= S_SCL_R;
                end
                S_SCL_R:
                begin
                    if (out_free)
                    begin
                        left_out_reg  <= ltmp_reg;
                        right_out_reg <= sc_val;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    a_accept_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_NORM)
        else $error("Accepted word did not start normalization.");

    a_gain_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= 32'sd0)
        else $error("Smoothed log gain became positive.");

    a_glin_max: assert property (@(posedge clk) disable iff (!rst_n)
        glin_reg <= (31'd1 << 30))
        else $error("Linear gain exceeds unity.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_SCL_R)
        else $error("Output word loaded outside the final scaling step.");

endmodule
